// File: sv/assert_macros.svh
// Assertion macros shared by the token scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Concurrent check on the default clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_RST(lbl, clk_i, rst_ni, prop)

`endif

// File: sv/rtss_pkg.sv
// Package for the random start token scheduler: types, codes and defaults.
// No dependencies; used by rtss_ram and random_start_token_scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rtss_pkg;

  localparam int MaxRequestersDef = 64;
  localparam logic [31:0] TimeoutRst = 32'd200_000_000;
  localparam int StateW = 2;
  localparam int TimeW = 64;
  localparam int RndW = 32;
  localparam int IdW = 7;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_SYNC     = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } opcode_e;

  typedef enum logic [StateW-1:0] {
    RS_UNKNOWN = 2'd0,
    RS_RUNNING = 2'd1,
    RS_WAITING = 2'd2,
    RS_TIMEOUT = 2'd3
  } req_state_e;

  typedef struct packed {
    logic           overflow_error;
    logic [IdW-1:0] assigned_id;
    logic           caller_waits;
    logic [IdW-1:0] granted_id;
    logic           granted;
  } result_t;

endpackage

`default_nettype wire

// File: sv/rtss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on rtss_pkg for parameter defaults.
`timescale 1ns / 1ps
`default_nettype none

module rtss_ram #(
  parameter int Width = rtss_pkg::StateW,
  parameter int Depth = rtss_pkg::MaxRequestersDef,
  localparam int Aw = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/random_start_token_scheduler.sv
// Path to the result: register goes S_IDLE to S_DONE; sync adds S_SYNC, and S_DIV and S_PICK
// when the token moves; tick adds S_AGE, then S_DIV and S_PICK if no requester is still running.
// One request in flight at a time; the rate is set by the state and time RAM
// scans (one entry a cycle) and the 32-step shift-subtract modulo unit.
// Reset clears the requester count, timeout (to 200000000 ns) and handshake
// state; no clearing pass runs, a state entry is written when its id is handed out.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module random_start_token_scheduler #(
  parameter int MaxRequesters = rtss_pkg::MaxRequestersDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i,     // timeout_ns
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,   // requester_id[6:0], random_value[38:7],
                                            // now[102:39]
  input  wire logic [1:0]   s_axis_tuser,   // opcode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [23:0]       m_axis_tdata    // granted[0], granted_id[7:1],
                                            // caller_waits[8], assigned_id[15:9],
                                            // overflow_error[16]
);

  localparam int CW = $clog2(MaxRequesters + 1);
  localparam int AW = $clog2(MaxRequesters);
  localparam int IW = (CW > rtss_pkg::IdW) ? CW : rtss_pkg::IdW;
  localparam int RW = rtss_pkg::RndW;
  localparam int TW = rtss_pkg::TimeW;
  localparam int SW = rtss_pkg::StateW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SYNC = 3'd1;
  localparam logic [2:0] S_AGE  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [31:0]                 timeout_q;
  logic                        m_tvalid_q, m_tvalid_d;
  logic                        chk_vld_q, chk_vld_d;
  rtss_pkg::result_t           m_tdata_q, m_tdata_d;
  rtss_pkg::result_t           res_q, res_d;
  logic [1:0]                  op_q, op_d;
  logic [rtss_pkg::IdW-1:0]    id_q, id_d;
  logic [RW-1:0]               rnd_q, rnd_d;
  logic [TW-1:0]               now_q, now_d;
  logic [AW-1:0]               iss_addr_q, iss_addr_d;
  logic [CW-1:0]               iss_cnt_q, iss_cnt_d;
  logic [AW-1:0]               chk_addr_q, chk_addr_d;
  logic                        anyrun_q, anyrun_d;
  logic [CW-1:0]               rem_q, rem_d;
  logic [4:0]                  step_q, step_d;
  logic [AW-1:0]               start_q, start_d;

  logic                        st_we;
  logic [AW-1:0]               st_waddr, st_raddr;
  logic [SW-1:0]               st_wdata, st_rdata;
  logic                        tm_we;
  logic [AW-1:0]               tm_waddr;
  logic [TW-1:0]               tm_rdata;

  logic [rtss_pkg::IdW-1:0]    in_id;
  logic                        in_id_ok;
  logic                        issue;
  logic [AW-1:0]               iss_next;
  logic [TW:0]                 age;
  logic                        expired;
  logic [CW:0]                 shifted;
  logic [AW-1:0]               g_addr;
  logic [CW-1:0]               g_id;
  logic                        do_grant;

  assign in_id = s_axis_tdata[6:0];
  assign in_id_ok = (in_id != '0) && (IW'(in_id) <= IW'(cnt_q));
  assign issue = (iss_cnt_q != cnt_q);
  assign iss_next = ((CW'(iss_addr_q) + CW'(1)) == cnt_q) ? '0 : iss_addr_q + AW'(1);
  assign age = {1'b0, now_q} - {1'b0, tm_rdata};
  assign expired = !age[TW] && (age[TW-1:0] >= {{(TW-32){1'b0}}, timeout_q});
  assign shifted = {rem_q, rnd_q[RW-1]};
  assign g_id = CW'(g_addr) + CW'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    m_tvalid_d = m_tvalid_q;
    m_tdata_d  = m_tdata_q;
    chk_vld_d  = chk_vld_q;
    res_d      = res_q;
    op_d       = op_q;
    id_d       = id_q;
    rnd_d      = rnd_q;
    now_d      = now_q;
    iss_addr_d = iss_addr_q;
    iss_cnt_d  = iss_cnt_q;
    chk_addr_d = chk_addr_q;
    anyrun_d   = anyrun_q;
    rem_d      = rem_q;
    step_d     = step_q;
    start_d    = start_q;
    st_we      = 1'b0;
    st_waddr   = chk_addr_q;
    st_wdata   = rtss_pkg::RS_UNKNOWN;
    st_raddr   = iss_addr_q;
    tm_we      = 1'b0;
    g_addr     = start_q;
    do_grant   = 1'b0;

    if (m_tvalid_q && m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    // advance the read pipeline of a scan
    if (state_q == S_AGE || state_q == S_PICK) begin
      if (issue) begin
        iss_addr_d = iss_next;
        iss_cnt_d  = iss_cnt_q + CW'(1);
        chk_vld_d  = 1'b1;
        chk_addr_d = iss_addr_q;
      end else begin
        chk_vld_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        chk_vld_d = 1'b0;
        if (s_axis_tvalid) begin
          op_d  = s_axis_tuser;
          id_d  = in_id;
          rnd_d = s_axis_tdata[38:7];
          now_d = s_axis_tdata[102:39];
          res_d = '0;
          state_d = S_DONE;
          unique case (rtss_pkg::opcode_e'(s_axis_tuser))
            rtss_pkg::OP_REGISTER: begin
              if (cnt_q == CW'(MaxRequesters)) begin
                res_d.overflow_error = 1'b1;
              end else begin
                st_we    = 1'b1;
                st_waddr = cnt_q[AW-1:0];
                st_wdata = rtss_pkg::RS_UNKNOWN;
                cnt_d    = cnt_q + CW'(1);
                res_d.assigned_id = rtss_pkg::IdW'(cnt_q + CW'(1));
              end
            end
            rtss_pkg::OP_SYNC: begin
              if (in_id_ok) begin
                st_raddr = AW'(IW'(in_id) - IW'(1));
                state_d  = S_SYNC;
              end
            end
            rtss_pkg::OP_TICK: begin
              if (cnt_q != '0) begin
                iss_addr_d = '0;
                iss_cnt_d  = '0;
                anyrun_d   = 1'b0;
                state_d    = S_AGE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SYNC: begin
        st_we    = 1'b1;
        st_waddr = AW'(IW'(id_q) - IW'(1));
        st_wdata = rtss_pkg::RS_WAITING;
        if (st_rdata == rtss_pkg::RS_RUNNING) begin
          rem_d   = '0;
          step_d  = '0;
          state_d = S_DIV;
        end else begin
          res_d.caller_waits = 1'b1;
          state_d = S_DONE;
        end
      end
      S_AGE: begin
        if (chk_vld_q && st_rdata == rtss_pkg::RS_RUNNING) begin
          if (expired) begin
            st_we    = 1'b1;
            st_waddr = chk_addr_q;
            st_wdata = rtss_pkg::RS_TIMEOUT;
          end else begin
            anyrun_d = 1'b1;
          end
        end
        if (!issue && !chk_vld_q) begin
          if (anyrun_q) begin
            state_d = S_DONE;
          end else begin
            rem_d   = '0;
            step_d  = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (shifted >= {1'b0, cnt_q}) begin
          rem_d = CW'(shifted - {1'b0, cnt_q});
        end else begin
          rem_d = shifted[CW-1:0];
        end
        rnd_d  = rnd_q << 1;
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          start_d    = rem_d[AW-1:0];
          iss_addr_d = (({1'b0, rem_d} + (CW+1)'(1)) == {1'b0, cnt_q}) ?
                       '0 : rem_d[AW-1:0] + AW'(1);
          iss_cnt_d  = '0;
          chk_vld_d  = 1'b0;
          state_d    = S_PICK;
        end
      end
      S_PICK: begin
        if (chk_vld_q && st_rdata == rtss_pkg::RS_WAITING) begin
          g_addr   = chk_addr_q;
          do_grant = 1'b1;
        end else if (!issue && !chk_vld_q) begin
          g_addr   = start_q;
          do_grant = 1'b1;
        end
        if (do_grant) begin
          st_we    = 1'b1;
          st_waddr = g_addr;
          st_wdata = rtss_pkg::RS_RUNNING;
          tm_we    = 1'b1;
          res_d.granted      = 1'b1;
          res_d.granted_id   = rtss_pkg::IdW'(g_id);
          res_d.caller_waits = (op_q == rtss_pkg::OP_SYNC) && (IW'(g_id) != IW'(id_q));
          chk_vld_d = 1'b0;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = res_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign tm_waddr = g_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      timeout_q  <= rtss_pkg::TimeoutRst;
      m_tvalid_q <= 1'b0;
      chk_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      m_tvalid_q <= m_tvalid_d;
      chk_vld_q  <= chk_vld_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_tdata_q  <= m_tdata_d;
    res_q      <= res_d;
    op_q       <= op_d;
    id_q       <= id_d;
    rnd_q      <= rnd_d;
    now_q      <= now_d;
    iss_addr_q <= iss_addr_d;
    iss_cnt_q  <= iss_cnt_d;
    chk_addr_q <= chk_addr_d;
    anyrun_q   <= anyrun_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    start_q    <= start_d;
  end

  rtss_ram #(
    .Width (SW),
    .Depth (MaxRequesters)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rtss_ram #(
    .Width (TW),
    .Depth (MaxRequesters)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (now_q),
    .raddr_i (iss_addr_q),
    .rdata_o (tm_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {7'b0, m_tdata_q};

  `ASSERT_STD(a_accept_busy, (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
  `ASSERT_STD(a_cnt_cap, cnt_q <= CW'(MaxRequesters))
  `ASSERT_STD(a_chk_in_range, chk_vld_q |-> (CW'(chk_addr_q) < cnt_q))

endmodule

`default_nettype wire
